// ===== design/owm_pkg.sv =====
package owm_pkg;

   // Width of the microsecond down counter and the fixed gap after a written bit.
   localparam int TIME_BITS  = 10;
   localparam int BIT_GAP_US = 5;
   localparam int TIME_MAX   = (1 << TIME_BITS) - 1;

   localparam int CFG_BITS  = 10;
   localparam int CFG_COUNT = 8;
   localparam int CFG_IDX_BITS = $clog2(CFG_COUNT);

   typedef logic [TIME_BITS-1:0]    time_type;
   typedef logic [CFG_BITS-1:0]     cfg_type;
   typedef logic [CFG_IDX_BITS-1:0] cfg_idx_type;
   typedef logic [1:0]              opcode_type;
   typedef logic [3:0]              phase_type;

   // Register indexes.
   localparam cfg_idx_type CFG_RESET_LOW       = 3'd0;
   localparam cfg_idx_type CFG_PRESENCE_SAMPLE = 3'd1;
   localparam cfg_idx_type CFG_RESET_RECOVERY  = 3'd2;
   localparam cfg_idx_type CFG_WRITE_SHORT     = 3'd3;
   localparam cfg_idx_type CFG_WRITE_LONG      = 3'd4;
   localparam cfg_idx_type CFG_READ_LOW        = 3'd5;
   localparam cfg_idx_type CFG_READ_SAMPLE     = 3'd6;
   localparam cfg_idx_type CFG_READ_RECOVERY   = 3'd7;

   localparam cfg_type CFG_RESET_VALUE [CFG_COUNT] = '{
      10'd485, 10'd65, 10'd500, 10'd3, 10'd65, 10'd2, 10'd13, 10'd45
   };

   // Command codes.
   localparam opcode_type OP_TICK  = 2'd0;
   localparam opcode_type OP_RESET = 2'd1;
   localparam opcode_type OP_WRITE = 2'd2;
   localparam opcode_type OP_READ  = 2'd3;

   // Bus sequencer phases.
   localparam phase_type PH_IDLE     = 4'd0;
   localparam phase_type PH_RST_LOW  = 4'd1;
   localparam phase_type PH_RST_WAIT = 4'd2;
   localparam phase_type PH_RST_REC  = 4'd3;
   localparam phase_type PH_WR_LOW   = 4'd4;
   localparam phase_type PH_WR_HIGH  = 4'd5;
   localparam phase_type PH_WR_GAP   = 4'd6;
   localparam phase_type PH_RD_LOW   = 4'd7;
   localparam phase_type PH_RD_WAIT  = 4'd8;
   localparam phase_type PH_RD_REC   = 4'd9;

   // Clamp a register duration to what the counter can hold.
   function automatic time_type sat_time(cfg_type dur);
      time_type res;
      if (32'(dur) > TIME_MAX) begin
         res = '1;
      end else begin
         res = TIME_BITS'(dur);
      end
      return res;
   endfunction

endpackage

// ===== design/owm_if.sv =====
interface owm_req_if;
   import owm_pkg::*;
   logic       valid;
   logic       ready;
   opcode_type opcode;
   logic [7:0] write_value;
   logic       line_level;
   modport source (output valid, opcode, write_value, line_level, input ready);
   modport sink   (input valid, opcode, write_value, line_level, output ready);
endinterface

interface owm_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_value;
   logic       no_presence;
   logic       rejected;
   modport source (output valid, drive_low, busy_res, done_res, read_value, no_presence,
                   rejected, input ready);
   modport sink   (input valid, drive_low, busy_res, done_res, read_value, no_presence,
                   rejected, output ready);
endinterface

interface owm_csr_if;
   import owm_pkg::*;
   logic        valid;
   logic        ready;
   cfg_idx_type index;
   cfg_type     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/one_wire_master.sv =====
// One-wire bus master, paced by microsecond tick beats.
// Each beat on the request channel is either a tick (one microsecond gone by)
// or a command: bus reset, write byte or read byte. Commands start only while
// the master is idle; one that arrives while busy is ignored and its response
// beat has rejected set. Every request beat yields exactly one response beat
// that shows the state after it: whether the line is pulled low, busy, done on
// the tick that ends an operation, the last byte read and the presence flag.
// The line_level field must carry the sampled bus level with every beat.
// Timing registers (in microseconds) are written on the csr channel, which is
// always ready; write them only while the master is idle with no beats in
// flight.
// A request beat passes one input stage register, then a single pass through
// the phase and counter update into the response register. Throughput is one
// beat per cycle. When the response side stalls, the input stage holds its
// beat and the request side stays ready until that stage is full as well.
// A synchronous reset clears the sequencer to idle, both stages to empty and
// the timing registers to their default values.
module one_wire_master (
   input logic clock,
   input logic reset,
   owm_req_if.sink   req_bus,
   owm_rsp_if.source rsp_bus,
   owm_csr_if.sink   csr_bus
);
   import owm_pkg::*;

   // Timing registers.
   cfg_type cfg_ff [CFG_COUNT];

   // Input stage.
   logic       s1_valid_ff, s1_valid_in;
   opcode_type s1_opcode_ff;
   logic [7:0] s1_wval_ff;
   logic       s1_line_ff;

   // Sequencer state.
   phase_type  phase_ff, phase_in;
   time_type   time_left_ff, time_left_in;
   logic [2:0] bit_index_ff, bit_index_in;
   logic [7:0] shift_byte_ff, shift_byte_in;
   logic [7:0] last_read_ff, last_read_in;
   logic       presence_ff, presence_in;

   // Response register.
   logic       out_valid_ff, out_valid_in;
   logic       drive_low_ff, drive_low_in;
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic       rejected_ff, rejected_in;

   logic       advance;
   logic       req_take;
   time_type   tl_dec;
   logic       nx_bit;

   // The stage moves forward when the response register is empty or drained.
   assign advance  = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_take = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign s1_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CFG_COUNT; i++) begin
            cfg_ff[i] <= CFG_RESET_VALUE[i];
         end
      end else if (csr_bus.valid) begin
         cfg_ff[csr_bus.index] <= csr_bus.data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_opcode_ff <= req_bus.opcode;
         s1_wval_ff   <= req_bus.write_value;
         s1_line_ff   <= req_bus.line_level;
      end
   end

   // Single pass: one beat's effect on the sequencer.
   always_comb begin
      phase_in      = phase_ff;
      time_left_in  = time_left_ff;
      bit_index_in  = bit_index_ff;
      shift_byte_in = shift_byte_ff;
      last_read_in  = last_read_ff;
      presence_in   = presence_ff;
      done_in       = 1'b0;
      rejected_in   = 1'b0;
      tl_dec        = (time_left_ff != '0) ? time_left_ff - 1'b1 : '0;
      nx_bit        = 1'b0;

      if (s1_opcode_ff != OP_TICK) begin
         if (phase_ff != PH_IDLE) begin
            rejected_in = 1'b1;
         end else begin
            case (s1_opcode_ff)
               OP_RESET: begin
                  phase_in     = PH_RST_LOW;
                  time_left_in = sat_time(cfg_ff[CFG_RESET_LOW]);
               end
               OP_WRITE: begin
                  shift_byte_in = s1_wval_ff;
                  bit_index_in  = 3'd0;
                  phase_in      = PH_WR_LOW;
                  time_left_in  = s1_wval_ff[0] ? sat_time(cfg_ff[CFG_WRITE_SHORT])
                                                : sat_time(cfg_ff[CFG_WRITE_LONG]);
               end
               default: begin
                  shift_byte_in = 8'd0;
                  bit_index_in  = 3'd0;
                  phase_in      = PH_RD_LOW;
                  time_left_in  = sat_time(cfg_ff[CFG_READ_LOW]);
               end
            endcase
         end
      end else if (phase_ff != PH_IDLE) begin
         time_left_in = tl_dec;
         if (tl_dec == '0) begin
            case (phase_ff)
               PH_RST_LOW: begin
                  phase_in     = PH_RST_WAIT;
                  time_left_in = sat_time(cfg_ff[CFG_PRESENCE_SAMPLE]);
               end
               PH_RST_WAIT: begin
                  presence_in  = s1_line_ff;
                  phase_in     = PH_RST_REC;
                  time_left_in = sat_time(cfg_ff[CFG_RESET_RECOVERY]);
               end
               PH_RST_REC: begin
                  phase_in     = PH_IDLE;
                  time_left_in = '0;
                  done_in      = 1'b1;
               end
               PH_WR_LOW: begin
                  phase_in     = PH_WR_HIGH;
                  time_left_in = shift_byte_ff[bit_index_ff]
                                 ? sat_time(cfg_ff[CFG_WRITE_LONG])
                                 : sat_time(cfg_ff[CFG_WRITE_SHORT]);
               end
               PH_WR_HIGH: begin
                  phase_in     = PH_WR_GAP;
                  time_left_in = TIME_BITS'(BIT_GAP_US);
               end
               PH_WR_GAP: begin
                  if (bit_index_ff == 3'd7) begin
                     bit_index_in = 3'd0;
                     phase_in     = PH_IDLE;
                     time_left_in = '0;
                     done_in      = 1'b1;
                  end else begin
                     bit_index_in = bit_index_ff + 3'd1;
                     nx_bit       = shift_byte_ff[bit_index_in];
                     phase_in     = PH_WR_LOW;
                     time_left_in = nx_bit ? sat_time(cfg_ff[CFG_WRITE_SHORT])
                                           : sat_time(cfg_ff[CFG_WRITE_LONG]);
                  end
               end
               PH_RD_LOW: begin
                  phase_in     = PH_RD_WAIT;
                  time_left_in = sat_time(cfg_ff[CFG_READ_SAMPLE]);
               end
               PH_RD_WAIT: begin
                  // Bits arrive LSB first, so shift right and insert at the top.
                  shift_byte_in = {s1_line_ff, shift_byte_ff[7:1]};
                  phase_in      = PH_RD_REC;
                  time_left_in  = sat_time(cfg_ff[CFG_READ_RECOVERY]);
               end
               PH_RD_REC: begin
                  if (bit_index_ff == 3'd7) begin
                     bit_index_in = 3'd0;
                     last_read_in = shift_byte_ff;
                     phase_in     = PH_IDLE;
                     time_left_in = '0;
                     done_in      = 1'b1;
                  end else begin
                     bit_index_in = bit_index_ff + 3'd1;
                     phase_in     = PH_RD_LOW;
                     time_left_in = sat_time(cfg_ff[CFG_READ_LOW]);
                  end
               end
               default: begin
                  phase_in     = PH_IDLE;
                  time_left_in = '0;
               end
            endcase
         end
      end

      drive_low_in = (phase_in == PH_RST_LOW) || (phase_in == PH_WR_LOW)
                     || (phase_in == PH_RD_LOW);
      busy_in      = phase_in != PH_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         phase_ff      <= PH_IDLE;
         time_left_ff  <= '0;
         bit_index_ff  <= 3'd0;
         shift_byte_ff <= 8'd0;
         last_read_ff  <= 8'd0;
         presence_ff   <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff      <= phase_in;
            time_left_ff  <= time_left_in;
            bit_index_ff  <= bit_index_in;
            shift_byte_ff <= shift_byte_in;
            last_read_ff  <= last_read_in;
            presence_ff   <= presence_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         drive_low_ff <= drive_low_in;
         busy_ff      <= busy_in;
         done_ff      <= done_in;
         rejected_ff  <= rejected_in;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.drive_low   = drive_low_ff;
   assign rsp_bus.busy_res    = busy_ff;
   assign rsp_bus.done_res    = done_ff;
   assign rsp_bus.read_value  = last_read_ff;
   assign rsp_bus.no_presence = presence_ff;
   assign rsp_bus.rejected    = rejected_ff;

`ifndef NO_ASSERTIONS
   // The counter is always cleared when the sequencer goes idle.
   a_idle_timer_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> time_left_ff == '0)
      else $error("time_left nonzero while idle");

   // A bit position other than zero only exists inside a byte transfer.
   a_bit_index_idle: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> bit_index_ff == 3'd0)
      else $error("bit_index left over after a transfer");

   // A finishing beat always reports the master as no longer busy.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && done_ff |-> !busy_ff && !rejected_ff)
      else $error("done reported while busy or rejected");

   // The sequencer only moves when a beat leaves the input stage.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff) && $stable(time_left_ff))
      else $error("sequencer state changed without a beat");
`endif

endmodule

// ===== tb/one_wire_master_tb.sv =====
module one_wire_master_tb;
   import owm_pkg::*;

   // One request beat as the sender offers it.
   typedef struct packed {
      opcode_type opcode;
      logic [7:0] write_value;
      logic       line_level;
   } bus_req_type;

   // One response beat as the master should report it.
   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_value;
      logic       no_presence;
      logic       rejected;
   } bus_rsp_type;

   // How the sampled line level is chosen for the ticks of an operation.
   localparam int LINE_LOW  = 0;
   localparam int LINE_HIGH = 1;
   localparam int LINE_RAND = 2;

   logic clock = 1'b0;
   logic reset = 1'b1;

   owm_req_if req_bus ();
   owm_rsp_if rsp_bus ();
   owm_csr_if csr_bus ();

   one_wire_master i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Beats waiting to be offered, and the responses owed for accepted beats.
   bus_req_type beat_queue [$];
   bus_rsp_type rsp_expect [$];

   // Traffic shaping shared by the driver, the monitor and the stimulus.
   bit steady   = 1'b0;   // no random idling on either side while set
   bit hold_go  = 1'b0;   // asks for one long response hold-off
   logic hold_rsp = 1'b0;

   int n_beats    = 0;
   int n_checked  = 0;
   int n_done     = 0;
   int n_rejected = 0;
   int n_cfg      = 0;
   int n_errors   = 0;
   int rand_items = 0;

   // ------------------------------------------------------------------
   // Bus sequencer mirror. It is advanced once per accepted request beat,
   // in acceptance order, and its timing registers follow the csr writes.
   // ------------------------------------------------------------------
   phase_type  seq_phase;
   time_type   seq_left;
   logic [2:0] seq_bit;
   logic [7:0] seq_shift;
   logic [7:0] seq_last_read;
   logic       seq_presence;
   cfg_type    seq_cfg [CFG_COUNT];

   function automatic void clear_sequencer();
      seq_phase     = PH_IDLE;
      seq_left      = '0;
      seq_bit       = '0;
      seq_shift     = '0;
      seq_last_read = '0;
      seq_presence  = 1'b0;
      seq_cfg       = CFG_RESET_VALUE;
   endfunction

   // Enter a phase; a duration the counter cannot hold is pinned at its top.
   function automatic void enter_phase(phase_type ph, cfg_type dur);
      seq_phase = ph;
      if (int'(dur) > TIME_MAX) begin
         seq_left = '1;
      end else begin
         seq_left = time_type'(dur);
      end
   endfunction

   // The low part of a write slot is short for a one and long for a zero.
   function automatic void start_write_slot();
      enter_phase(PH_WR_LOW, seq_shift[seq_bit] ? seq_cfg[CFG_WRITE_SHORT]
                                                : seq_cfg[CFG_WRITE_LONG]);
   endfunction

   function automatic bus_rsp_type sequence_beat(bus_req_type r);
      bus_rsp_type o;
      logic        done;
      logic        rej;
      done = 1'b0;
      rej  = 1'b0;
      if (r.opcode != OP_TICK) begin
         // A command only starts an operation; it never counts as a tick.
         if (seq_phase != PH_IDLE) begin
            rej = 1'b1;
         end else if (r.opcode == OP_RESET) begin
            enter_phase(PH_RST_LOW, seq_cfg[CFG_RESET_LOW]);
         end else if (r.opcode == OP_WRITE) begin
            seq_shift = r.write_value;
            seq_bit   = '0;
            start_write_slot();
         end else begin
            seq_shift = '0;
            seq_bit   = '0;
            enter_phase(PH_RD_LOW, seq_cfg[CFG_READ_LOW]);
         end
      end else if (seq_phase != PH_IDLE) begin
         // A zero duration still ends on the first tick.
         if (seq_left != 0) seq_left = seq_left - 1'b1;
         if (seq_left == 0) begin
            case (seq_phase)
               PH_RST_LOW: begin
                  enter_phase(PH_RST_WAIT, seq_cfg[CFG_PRESENCE_SAMPLE]);
               end
               PH_RST_WAIT: begin
                  seq_presence = r.line_level;
                  enter_phase(PH_RST_REC, seq_cfg[CFG_RESET_RECOVERY]);
               end
               PH_RST_REC: begin
                  enter_phase(PH_IDLE, '0);
                  done = 1'b1;
               end
               PH_WR_LOW: begin
                  enter_phase(PH_WR_HIGH, seq_shift[seq_bit] ? seq_cfg[CFG_WRITE_LONG]
                                                             : seq_cfg[CFG_WRITE_SHORT]);
               end
               PH_WR_HIGH: begin
                  enter_phase(PH_WR_GAP, cfg_type'(BIT_GAP_US));
               end
               PH_WR_GAP: begin
                  // The gap follows the eighth bit as well.
                  if (seq_bit == 3'd7) begin
                     seq_bit = '0;
                     enter_phase(PH_IDLE, '0);
                     done = 1'b1;
                  end else begin
                     seq_bit = seq_bit + 1'b1;
                     start_write_slot();
                  end
               end
               PH_RD_LOW: begin
                  enter_phase(PH_RD_WAIT, seq_cfg[CFG_READ_SAMPLE]);
               end
               PH_RD_WAIT: begin
                  seq_shift = {r.line_level, seq_shift[7:1]};
                  enter_phase(PH_RD_REC, seq_cfg[CFG_READ_RECOVERY]);
               end
               PH_RD_REC: begin
                  if (seq_bit == 3'd7) begin
                     seq_bit       = '0;
                     seq_last_read = seq_shift;
                     enter_phase(PH_IDLE, '0);
                     done = 1'b1;
                  end else begin
                     seq_bit = seq_bit + 1'b1;
                     enter_phase(PH_RD_LOW, seq_cfg[CFG_READ_LOW]);
                  end
               end
               default: begin
                  enter_phase(PH_IDLE, '0);
               end
            endcase
         end
      end
      o.drive_low   = (seq_phase == PH_RST_LOW) || (seq_phase == PH_WR_LOW) ||
                      (seq_phase == PH_RD_LOW);
      o.busy_res    = (seq_phase != PH_IDLE);
      o.done_res    = done;
      o.read_value  = seq_last_read;
      o.no_presence = seq_presence;
      o.rejected    = rej;
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Request driver. A beat that is offered stays on the bus until it is
   // taken; otherwise the next queued beat goes out unless this cycle idles.
   // The mirror is advanced right here, at the edge that accepts the beat.
   // ------------------------------------------------------------------
   initial begin
      req_bus.valid       = 1'b0;
      req_bus.opcode      = OP_TICK;
      req_bus.write_value = '0;
      req_bus.line_level  = 1'b1;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = '0;
      csr_bus.data        = '0;
   end

   always @(posedge clock) begin
      bus_req_type took;
      bus_req_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         clear_sequencer();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            took.opcode      = req_bus.opcode;
            took.write_value = req_bus.write_value;
            took.line_level  = req_bus.line_level;
            rsp_expect.push_back(sequence_beat(took));
            n_beats++;
         end
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (beat_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
               nxt = beat_queue.pop_front();
               req_bus.opcode      <= nxt.opcode;
               req_bus.write_value <= nxt.write_value;
               req_bus.line_level  <= nxt.line_level;
               req_bus.valid       <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor. Every response beat is matched against the oldest
   // outstanding expectation, one field at a time.
   // ------------------------------------------------------------------
   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         n_errors++;
      end
   endtask

   always @(posedge clock) begin
      bus_rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (rsp_expect.size() == 0) begin
               $error("response beat arrived with no request outstanding");
               n_errors++;
            end else begin
               want = rsp_expect.pop_front();
               check_field("drive_low", want.drive_low, rsp_bus.drive_low);
               check_field("busy_res", want.busy_res, rsp_bus.busy_res);
               check_field("done_res", want.done_res, rsp_bus.done_res);
               check_field("read_value", want.read_value, rsp_bus.read_value);
               check_field("no_presence", want.no_presence, rsp_bus.no_presence);
               check_field("rejected", want.rejected, rsp_bus.rejected);
               n_checked++;
               if (want.done_res) n_done++;
               if (want.rejected) n_rejected++;
            end
         end
         rsp_bus.ready <= !hold_rsp && (steady || $urandom_range(0, 99) >= 25);
      end
   end

   // One long hold-off on the response side. The sender keeps offering
   // beats meanwhile, so the master's stages fill and it stops taking more.
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (300) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------
   function automatic logic pick_line(int mode);
      if (mode == LINE_RAND) return logic'($urandom_range(0, 1));
      return (mode == LINE_HIGH);
   endfunction

   task automatic push_beat(opcode_type op, logic [7:0] wv, logic line);
      bus_req_type b;
      b.opcode      = op;
      b.write_value = wv;
      b.line_level  = line;
      beat_queue.push_back(b);
   endtask

   task automatic push_ticks(int count, int mode);
      for (int i = 0; i < count; i++) begin
         push_beat(OP_TICK, 8'($urandom), pick_line(mode));
      end
   endtask

   function automatic int at_least_one(cfg_type v);
      return (v == 0) ? 1 : int'(v);
   endfunction

   // Ticks an operation needs under the current timing registers.
   function automatic int op_length_us(opcode_type op);
      case (op)
         OP_RESET: return at_least_one(seq_cfg[CFG_RESET_LOW]) +
                          at_least_one(seq_cfg[CFG_PRESENCE_SAMPLE]) +
                          at_least_one(seq_cfg[CFG_RESET_RECOVERY]);
         OP_WRITE: return 8 * (at_least_one(seq_cfg[CFG_WRITE_SHORT]) +
                               at_least_one(seq_cfg[CFG_WRITE_LONG]) +
                               at_least_one(cfg_type'(BIT_GAP_US)));
         OP_READ:  return 8 * (at_least_one(seq_cfg[CFG_READ_LOW]) +
                               at_least_one(seq_cfg[CFG_READ_SAMPLE]) +
                               at_least_one(seq_cfg[CFG_READ_RECOVERY]));
         default:  return 0;
      endcase
   endfunction

   // A command followed by exactly the ticks that carry it to completion.
   task automatic push_op(opcode_type op, logic [7:0] wv, int mode);
      push_beat(op, wv, pick_line(mode));
      push_ticks(op_length_us(op), mode);
   endtask

   // Wait until every queued beat has gone out and every response is in,
   // then leave the master quiet while it finishes its pipeline.
   // The bus is looked at on the falling edge, once the driver has settled.
   task automatic drain();
      @(negedge clock);
      while (beat_queue.size() != 0 || req_bus.valid || rsp_expect.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Also tick out any operation that is still running.
   task automatic settle();
      drain();
      while (seq_phase != PH_IDLE) begin
         push_ticks(64, LINE_RAND);
         drain();
      end
   endtask

   task automatic set_reg(cfg_idx_type idx, cfg_type val);
      @(posedge clock);
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      seq_cfg[idx] = val;
      n_cfg++;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_all_regs(cfg_type val);
      for (int r = 0; r < CFG_COUNT; r++) begin
         set_reg(cfg_idx_type'(r), val);
      end
   endtask

   // Small random timing for the random phases, with zero durations common.
   function automatic cfg_type random_us();
      int k;
      k = $urandom_range(0, 9);
      if (k < 2) return '0;
      if (k == 9) return cfg_type'($urandom_range(8, 24));
      return cfg_type'($urandom_range(1, 6));
   endfunction

   // A random operation: usually well formed, sometimes cut short so the
   // next command lands while busy, sometimes with a stray command inside.
   task automatic push_random_op();
      opcode_type op;
      int         k;
      int         ticks;
      int         cut;
      int         spot;
      int         mode;
      k = $urandom_range(0, 9);
      if (k < 2) begin
         op = OP_RESET;
      end else if (k < 6) begin
         op = OP_WRITE;
      end else begin
         op = OP_READ;
      end
      mode  = (op == OP_RESET) ? int'($urandom_range(0, 2)) : LINE_RAND;
      ticks = op_length_us(op) + $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) begin
         cut   = $urandom_range(1, 3);
         ticks = (ticks > cut) ? ticks - cut : 0;
      end
      push_beat(op, 8'($urandom), pick_line(mode));
      if ($urandom_range(0, 4) == 0) begin
         spot = $urandom_range(0, ticks);
         push_ticks(spot, mode);
         push_beat(opcode_type'($urandom_range(1, 3)), 8'($urandom), pick_line(mode));
         push_ticks(ticks - spot, mode);
         rand_items += 1;
      end else begin
         push_ticks(ticks, mode);
      end
      rand_items += ticks + 1;
   endtask

   // ------------------------------------------------------------------
   // Main sequence: directed operations under all-zero timing, then random
   // phases with fresh small timings each.
   // ------------------------------------------------------------------
   initial begin
      int phase_no;
      phase_no = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Ticks while idle change nothing.
      push_beat(OP_TICK, 8'h00, 1'b0);
      push_beat(OP_TICK, 8'hFF, 1'b1);
      settle();

      // All durations zero: every phase but the fixed write gap lasts a single tick.
      set_all_regs('0);

      // A high line at the sample means nobody answered. Every command
      // that follows the reset while it runs is turned away.
      push_beat(OP_RESET, 8'h00, 1'b1);
      push_beat(OP_WRITE, 8'hFF, 1'b1);
      push_beat(OP_READ, 8'h00, 1'b0);
      push_beat(OP_RESET, 8'h00, 1'b1);
      push_ticks(op_length_us(OP_RESET), LINE_HIGH);
      push_op(OP_RESET, 8'h00, LINE_LOW);
      push_op(OP_WRITE, 8'hA5, LINE_RAND);
      push_op(OP_WRITE, 8'h00, LINE_RAND);
      push_op(OP_WRITE, 8'hFF, LINE_RAND);
      push_op(OP_READ, 8'h00, LINE_HIGH);
      push_op(OP_READ, 8'h00, LINE_RAND);
      settle();

      // Random phases. The second one carries the response hold-off and
      // the third runs with no idling on either side.
      while (rand_items < 1000 || phase_no < 3) begin
         for (int r = 0; r < CFG_COUNT; r++) begin
            set_reg(cfg_idx_type'(r), random_us());
         end
         if (phase_no == 2) steady = 1'b1;
         repeat (5) push_random_op();
         if (phase_no == 1) hold_go = 1'b1;
         settle();
         steady = 1'b0;
         phase_no++;
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Sent %0d request beats over %0d random timing phases; %0d responses compared.",
               n_beats, phase_no, n_checked);
      $display("Saw %0d finished operations, %0d busy commands turned away, %0d csr writes.",
               n_done, n_rejected, n_cfg);
      if (n_errors == 0) begin
         $display("one_wire_master_tb: clean");
      end else begin
         $display("one_wire_master_tb: errors");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #50_000_000;
      $display("Run timed out with %0d responses still outstanding.", rsp_expect.size());
      $display("one_wire_master_tb: errors");
      $finish;
   end

endmodule

// ===== one_wire_master.f =====
design/owm_pkg.sv
design/owm_if.sv
design/one_wire_master.sv
tb/one_wire_master_tb.sv
